@@ rtl/kst_pkg.sv @@
// Package for the spanning tree block: default sizes and sequencer states.
// Used by kruskal_spanning_tree; no dependencies.
package kst_pkg;

  localparam int MAX_VERTICES_DEF = 8;
  localparam int WEIGHT_BITS_DEF  = 15;
  localparam int VERTEX_FIELD     = 3;
  localparam int CFG_BITS         = 4;
  localparam logic [CFG_BITS-1:0] VERTEX_COUNT_RST = 4'd8;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_EXTRACT,
    ST_EXT_WAIT,
    ST_SCAN,
    ST_FIND_A,
    ST_FIND_B,
    ST_EMIT,
    ST_CLEAR
  } kst_state_t;

endpackage

@@ rtl/kst_wmat.sv @@
// Weight matrix store: one write and one registered read per cycle.
// Per-entry valid bits make every entry read as no-edge after a clear.
// No dependencies.
module kst_wmat #(
  parameter int DEPTH = 64,
  parameter int WB    = 15,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [WB-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [WB-1:0] rd_data
);

  logic [WB-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= valid[rd_addr] ? mem[rd_addr] : {WB{1'b1}};
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

endmodule

@@ rtl/kruskal_spanning_tree.sv @@
// Top level of the spanning tree block: edge loading, extraction, ordered
// selection, union-find walk and result output. Uses kst_pkg and kst_wmat.
//
// Edges load at one item per cycle, while the block is in its load state,
// into the weight matrix memory (upper triangle only). The item with tlast
// set starts a run: a sweep reads the matrix and fills the edge list memory.
// Each result then takes one scan of the edge list (picking the next edge
// in weight order, ties in row order), two root walks that follow parent
// links, with the merge done in the last step of the second walk, and an
// output handshake. A final clear state clears the matrix, after which new
// edges are taken.
module kruskal_spanning_tree
  import kst_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF,
  localparam int DW = ((2 * VERTEX_FIELD + WEIGHT_BITS + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [DW-1:0]       s_tdata,  // start_vertex, end_vertex, edge_weight
  input  logic                s_tlast,  // last_edge
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [DW-1:0]       m_tdata,  // tree_start, tree_end, tree_weight
  output logic                m_tuser,  // in_tree
  output logic                m_tlast   // last_result
);

  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);
  localparam int VIW   = $clog2(MAX_VERTICES);
  localparam int VCW   = $clog2(MAX_VERTICES + 1);
  localparam int MAXE  = (MAX_VERTICES * (MAX_VERTICES - 1)) / 2;
  localparam int EW    = $clog2(MAXE + 1);
  localparam int EIW   = (MAXE > 1) ? $clog2(MAXE) : 1;
  localparam int LW    = 2 * VIW + WEIGHT_BITS;
  localparam logic [WEIGHT_BITS-1:0] NO_EDGE = {WEIGHT_BITS{1'b1}};

  kst_state_t state, state_next;

  logic [CFG_BITS-1:0] vertex_count;
  logic [VCW-1:0]      nv;

  // input item fields
  logic [VERTEX_FIELD-1:0] in_s, in_e, in_lo, in_hi;
  logic [WEIGHT_BITS-1:0]  in_w;
  logic                    in_acc, in_ok;

  // matrix ports
  logic          wm_wr, wm_clr;
  logic [AW-1:0] wm_waddr, wm_raddr;
  logic [WEIGHT_BITS-1:0] wm_rdata;

  // extraction sweep
  logic [VCW-1:0] ext_i, ext_j, ext_pi, ext_pj;
  logic           ext_pv, ext_add, ext_end;

  // edge list memory
  logic [LW-1:0]  el_mem [MAXE];
  logic [LW-1:0]  el_q;
  logic [EW-1:0]  total;

  // scan and selection
  logic [EW-1:0]  scan_addr, out_cnt;
  logic [EIW-1:0] sp_idx, best_idx, last_idx;
  logic           sp_v, best_found, have_last, scan_issue;
  logic [VIW-1:0] el_lo, el_hi, best_lo, best_hi;
  logic [WEIGHT_BITS-1:0] el_w, best_w, last_w;
  logic           above_last, below_best;

  // union-find
  logic [VIW-1:0] parent [MAX_VERTICES];
  logic [VIW-1:0] walk_v, ra, walk_p;
  logic           joined;

  assign cfg_ready = 1'b1;
  assign nv = (vertex_count > CFG_BITS'(MAX_VERTICES)) ? VCW'(MAX_VERTICES)
                                                       : VCW'(vertex_count);

  assign in_s   = s_tdata[VERTEX_FIELD-1:0];
  assign in_e   = s_tdata[2*VERTEX_FIELD-1:VERTEX_FIELD];
  assign in_w   = s_tdata[2*VERTEX_FIELD+WEIGHT_BITS-1:2*VERTEX_FIELD];
  assign in_lo  = (in_s < in_e) ? in_s : in_e;
  assign in_hi  = (in_s < in_e) ? in_e : in_s;
  assign s_tready = (state == ST_LOAD);
  assign in_acc = s_tvalid && s_tready;
  // diagonal entries are never extracted, so they are not stored
  assign in_ok  = ({1'b0, in_s} < 4'(MAX_VERTICES)) && ({1'b0, in_e} < 4'(MAX_VERTICES))
                  && (in_s != in_e);

  assign wm_wr    = in_acc && in_ok;
  assign wm_waddr = AW'(in_lo) * AW'(MAX_VERTICES) + AW'(in_hi);
  assign wm_raddr = AW'(ext_i) * AW'(MAX_VERTICES) + AW'(ext_j);
  assign wm_clr   = (state == ST_CLEAR);

  kst_wmat #(.DEPTH(DEPTH), .WB(WEIGHT_BITS)) u_wmat (
    .clk     (clk),
    .rst     (rst),
    .clr     (wm_clr),
    .wr_en   (wm_wr),
    .wr_addr (wm_waddr),
    .wr_data (in_w),
    .rd_addr (wm_raddr),
    .rd_data (wm_rdata)
  );

  assign ext_add = ext_pv && (wm_rdata != NO_EDGE);
  assign ext_end = (ext_j == nv - VCW'(1)) && (ext_i == nv - VCW'(2));

  assign el_lo = el_q[VIW-1:0];
  assign el_hi = el_q[2*VIW-1:VIW];
  assign el_w  = el_q[LW-1:2*VIW];
  assign above_last = !have_last || ({el_w, sp_idx} > {last_w, last_idx});
  assign below_best = !best_found || ({el_w, sp_idx} < {best_w, best_idx});
  assign scan_issue = (state == ST_SCAN) && (scan_addr < total);

  assign walk_p = parent[walk_v];

  always_ff @(posedge clk) begin
    if (ext_add) begin
      el_mem[total[EIW-1:0]] <= {wm_rdata, VIW'(ext_pj), VIW'(ext_pi)};
    end
    el_q <= el_mem[scan_addr[EIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_acc && s_tlast) begin
          state_next = (nv < VCW'(2)) ? ST_CLEAR : ST_EXTRACT;
        end
      end
      ST_EXTRACT:  if (ext_end) state_next = ST_EXT_WAIT;
      ST_EXT_WAIT: state_next = (total == '0 && !ext_add) ? ST_CLEAR : ST_SCAN;
      ST_SCAN:     if (!scan_issue && !sp_v) state_next = ST_FIND_A;
      ST_FIND_A:   if (walk_p == walk_v) state_next = ST_FIND_B;
      ST_FIND_B:   if (walk_p == walk_v) state_next = ST_EMIT;
      ST_EMIT: begin
        if (m_tready) begin
          state_next = (out_cnt + EW'(1) == total) ? ST_CLEAR : ST_SCAN;
        end
      end
      ST_CLEAR:    state_next = ST_LOAD;
      default:     state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RST;
    end else if (cfg_valid) begin
      vertex_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_pv   <= 1'b0;
      sp_v     <= 1'b0;
      m_tvalid <= 1'b0;
      total    <= '0;
      for (int v = 0; v < MAX_VERTICES; v++) parent[v] <= VIW'(v);
    end else begin
      ext_pv <= (state == ST_EXTRACT);
      sp_v   <= scan_issue;
      if (state == ST_LOAD) begin
        total <= '0;
      end else if (ext_add) begin
        total <= total + EW'(1);
      end
      case (state)
        ST_LOAD: begin
          ext_i <= '0;
          ext_j <= VCW'(1);
          out_cnt    <= '0;
          have_last  <= 1'b0;
          best_found <= 1'b0;
          scan_addr  <= '0;
          for (int v = 0; v < MAX_VERTICES; v++) parent[v] <= VIW'(v);
        end
        ST_EXTRACT: begin
          ext_pi <= ext_i;
          ext_pj <= ext_j;
          if (ext_j == nv - VCW'(1)) begin
            ext_i <= ext_i + VCW'(1);
            ext_j <= ext_i + VCW'(2);
          end else begin
            ext_j <= ext_j + VCW'(1);
          end
        end
        ST_SCAN: begin
          if (scan_issue) begin
            scan_addr <= scan_addr + EW'(1);
            sp_idx    <= scan_addr[EIW-1:0];
          end
          if (sp_v && above_last && below_best) begin
            best_found <= 1'b1;
            best_idx   <= sp_idx;
            best_lo    <= el_lo;
            best_hi    <= el_hi;
            best_w     <= el_w;
          end
          walk_v <= (sp_v && above_last && below_best) ? el_lo : best_lo;
        end
        ST_FIND_A: begin
          if (walk_p == walk_v) begin
            ra     <= walk_v;
            walk_v <= best_hi;
          end else begin
            walk_v <= walk_p;
          end
        end
        ST_FIND_B: begin
          if (walk_p == walk_v) begin
            joined   <= (ra != walk_v);
            if (ra != walk_v) parent[ra] <= walk_v;
            m_tvalid <= 1'b1;
          end else begin
            walk_v <= walk_p;
          end
        end
        ST_EMIT: begin
          if (m_tready) begin
            m_tvalid   <= 1'b0;
            out_cnt    <= out_cnt + EW'(1);
            have_last  <= 1'b1;
            last_w     <= best_w;
            last_idx   <= best_idx;
            best_found <= 1'b0;
            scan_addr  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = DW'({best_w, VERTEX_FIELD'(best_hi), VERTEX_FIELD'(best_lo)});
  assign m_tuser = joined;
  assign m_tlast = (out_cnt + EW'(1) == total);

endmodule
